// ===== design/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg: shared definitions for the power throttle monitor
// Field widths, register indexes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package ptm_pkg;

   localparam int ENERGY_W = 64;
   localparam int TIME_W   = 24;
   localparam int FREQ_W   = 24;
   localparam int POWER_W  = 32;
   localparam int DUTY_W   = 14;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // microwatts per watt, as a 20-bit multiplier constant
   localparam int          UW_W       = 20;
   localparam logic [19:0] UW_PER_W   = 20'd1000000;
   localparam logic [23:0] SIM_DIVISOR = 24'd10;

   localparam int DUTY_PERIOD_US_DEF = 10000;

   localparam logic [CSR_AW-1:0] REG_MANUAL_MODE = 3'd0;
   localparam logic [CSR_AW-1:0] REG_SIMULATE    = 3'd1;
   localparam logic [CSR_AW-1:0] REG_HIGH_THR    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_LOW_THR     = 3'd3;
   localparam logic [CSR_AW-1:0] REG_DUTY_ON     = 3'd4;
   localparam logic [CSR_AW-1:0] REG_SIM_IDLE    = 3'd5;
   localparam logic [CSR_AW-1:0] REG_SIM_ACTIVE  = 3'd6;

   localparam logic [POWER_W-1:0] HIGH_THR_RST   = 32'd40000000;
   localparam logic [POWER_W-1:0] LOW_THR_RST    = 32'd30000000;
   localparam logic [DUTY_W-1:0]  DUTY_ON_RST    = 14'd5000;
   localparam logic [POWER_W-1:0] SIM_IDLE_RST   = 32'd5000000;
   localparam logic [POWER_W-1:0] SIM_ACTIVE_RST = 32'd50000000;

   localparam logic [POWER_W-1:0] POWER_MAX = '1;
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

   typedef logic [POWER_W-1:0] power_type;

endpackage

// ===== design/ptm_if.sv =====
// ----------------------------------------------------------------------------
// ptm_if: request, response and register-write channels
// Valid/ready channels with source and sink views.
// ----------------------------------------------------------------------------
interface ptm_req_if
   import ptm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] energy_count_uj;
   logic                energy_valid;
   logic [TIME_W-1:0]   elapsed_us;
   logic [FREQ_W-1:0]   core_khz;

   modport source (output valid, energy_count_uj, energy_valid, elapsed_us, core_khz,
                   input ready);
   modport sink   (input valid, energy_count_uj, energy_valid, elapsed_us, core_khz,
                   output ready);
endinterface

interface ptm_rsp_if
   import ptm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [POWER_W-1:0] power_uw;
   logic [FREQ_W-1:0]  freq_out_khz;
   logic               throttled;

   modport source (output valid, power_uw, freq_out_khz, throttled, input ready);
   modport sink   (input valid, power_uw, freq_out_khz, throttled, output ready);
endinterface

interface ptm_csr_if
   import ptm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] addr;
   logic [CSR_DW-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== design/power_throttle_monitor.sv =====
// ----------------------------------------------------------------------------
// power_throttle_monitor: poll-rate power meter with throttle decision
// Turns energy counter samples into microwatts and drives a throttle request.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one poll sample per request; rsp_chan returns exactly one
//   result (power, frequency, throttle) per request, in order. csr_chan writes
//   the seven configuration registers; it is always ready, and the user must
//   write it only while no request is in flight (the block does not enforce this).
//   Path from acceptance to the response register: a sample that needs no
//   division goes straight to the load; simulated power while throttled runs
//   the restoring divider, and a measured power figure runs 4 multiply steps of
//   16 bits, one range check, 32 steps of the restoring divider and one load; a
//   saturated figure skips the divider. A new request is taken only
//   once the previous one has reached the response register, so the block does
//   not accept a new sample while the shared unit is still busy with the last.
//   The response register holds while rsp_chan.ready is low; the next request
//   is still taken and finishes up to the point of loading the response.
//   Reset (synchronous) restores the register defaults, drops the energy
//   baseline, clears the timers and leaves the throttle off.
// ----------------------------------------------------------------------------
module power_throttle_monitor
   import ptm_pkg::*;
#(
   parameter int DUTY_PERIOD_US = DUTY_PERIOD_US_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ptm_req_if.sink   req_chan,
   ptm_rsp_if.source rsp_chan,
   ptm_csr_if.sink   csr_chan
);

   localparam int PHASE_W = (DUTY_PERIOD_US > 1) ? $clog2(DUTY_PERIOD_US) : 1;
   localparam int PSUM_W  = ((PHASE_W > TIME_W) ? PHASE_W : TIME_W) + 1;
   localparam int PCMP_W  = (PHASE_W > DUTY_W) ? PHASE_W : DUTY_W;
   localparam int ACC_W   = ENERGY_W + UW_W;
   localparam int CHUNK_W = 16;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // configuration
   logic               manual_ff, sim_ff;
   logic [POWER_W-1:0] high_ff, low_ff, idle_ff, active_ff;
   logic [DUTY_W-1:0]  duty_on_ff;

   // block state
   logic [2:0]          state_ff, state_in;
   logic [ENERGY_W-1:0] last_ff, last_in;
   logic                base_ff, base_in;
   logic [TIME_W-1:0]   since_ff, since_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic                throttle_ff, throttle_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [ENERGY_W-1:0] mdata_ff, mdata_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [POWER_W-1:0]  quot_ff, quot_in;
   logic [TIME_W-1:0]   dvs_ff, dvs_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                sim_div_ff, sim_div_in;
   power_type           power_ff, power_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   power_type           rsp_power_ff, rsp_power_in;
   logic [FREQ_W-1:0]   rsp_freq_ff, rsp_freq_in;

   logic                req_take;
   logic [TIME_W:0]     tsum;
   logic [TIME_W-1:0]   tsat;
   logic [ENERGY_W:0]   ediff;
   logic                rise;
   logic [POWER_W-1:0]  sim_gap;
   logic [PSUM_W-1:0]   psum;
   logic [CHUNK_W+UW_W-1:0] prod;
   logic [TIME_W+1:0]   trial;
   logic                qbit;
   logic [POWER_W-1:0]  quot_next;
   logic                sat;
   logic                duty_on;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.power_uw     = rsp_power_ff;
   assign rsp_chan.freq_out_khz = rsp_freq_ff;
   assign rsp_chan.throttled    = throttle_ff;

   // sample arithmetic
   assign tsum    = {1'b0, since_ff} + {1'b0, req_chan.elapsed_us};
   assign tsat    = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
   assign ediff   = {1'b0, req_chan.energy_count_uj} - {1'b0, last_ff};
   assign rise    = !ediff[ENERGY_W] && (ediff[ENERGY_W-1:0] != '0);
   assign sim_gap = (active_ff >= idle_ff) ? (active_ff - idle_ff) : '0;
   assign psum    = PSUM_W'(phase_ff) + PSUM_W'(req_chan.elapsed_us);

   // shared multiply/divide unit
   assign prod      = mdata_ff[ENERGY_W-1 -: CHUNK_W] * UW_PER_W;
   assign trial     = {1'b0, rem_ff, quot_ff[POWER_W-1]} - {2'b0, dvs_ff};
   assign qbit      = !trial[TIME_W+1];
   assign quot_next = {quot_ff[POWER_W-2:0], qbit};
   assign sat       = acc_ff[ACC_W-1:POWER_W] >= (ACC_W-POWER_W)'(dvs_ff);
   assign duty_on   = PCMP_W'(phase_ff) < PCMP_W'(duty_on_ff);

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      since_in     = since_ff;
      phase_in     = phase_ff;
      throttle_in  = throttle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mdata_in     = mdata_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      sim_div_in   = sim_div_ff;
      power_in     = power_ff;
      freq_in      = freq_ff;
      rsp_power_in = rsp_power_ff;
      rsp_freq_in  = rsp_freq_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               freq_in    = req_chan.core_khz;
               phase_in   = (psum >= PSUM_W'(DUTY_PERIOD_US)) ? '0 : psum[PHASE_W-1:0];
               since_in   = tsat;
               power_in   = '0;
               sim_div_in = 1'b0;
               state_in   = S_DONE;
               if (sim_ff) begin
                  if (throttle_ff) begin
                     // idle plus a tenth of the gap, through the divider
                     sim_div_in = 1'b1;
                     rem_in     = '0;
                     quot_in    = sim_gap;
                     dvs_in     = SIM_DIVISOR;
                     cnt_in     = 5'(POWER_W - 1);
                     state_in   = S_DIV;
                  end else begin
                     power_in = active_ff;
                  end
               end else if (req_chan.energy_valid) begin
                  last_in  = req_chan.energy_count_uj;
                  since_in = '0;
                  base_in  = 1'b1;
                  if (base_ff && (tsat != '0) && rise) begin
                     mdata_in = ediff[ENERGY_W-1:0];
                     acc_in   = '0;
                     dvs_in   = tsat;
                     cnt_in   = 5'(ENERGY_W / CHUNK_W - 1);
                     state_in = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            // most significant chunk first: acc = acc * 2^16 + chunk * 1e6
            acc_in   = {acc_ff[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod);
            mdata_in = {mdata_ff[ENERGY_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            cnt_in   = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sat) begin
               power_in = POWER_MAX;
               state_in = S_DONE;
            end else begin
               // upper part is below the divisor, so it seeds the remainder
               rem_in   = acc_ff[POWER_W +: TIME_W];
               quot_in  = acc_ff[POWER_W-1:0];
               cnt_in   = 5'(POWER_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = qbit ? trial[TIME_W-1:0] : {rem_ff[TIME_W-2:0], quot_ff[POWER_W-1]};
            quot_in = quot_next;
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               power_in = sim_div_ff ? (idle_ff + quot_next) : quot_next;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = power_ff;
               rsp_freq_in  = freq_ff;
               if (manual_ff) begin
                  throttle_in = duty_on;
               end else if (power_ff > high_ff) begin
                  throttle_in = 1'b1;
               end else if (power_ff < low_ff) begin
                  throttle_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         base_ff      <= 1'b0;
         since_ff     <= '0;
         phase_ff     <= '0;
         throttle_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         sim_div_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         base_ff      <= base_in;
         since_ff     <= since_in;
         phase_ff     <= phase_in;
         throttle_ff  <= throttle_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         sim_div_ff   <= sim_div_in;
      end
   end

   always_ff @(posedge clock) begin
      mdata_ff     <= mdata_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      dvs_ff       <= dvs_in;
      power_ff     <= power_in;
      freq_ff      <= freq_in;
      rsp_power_ff <= rsp_power_in;
      rsp_freq_ff  <= rsp_freq_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff  <= 1'b0;
         sim_ff     <= 1'b0;
         high_ff    <= HIGH_THR_RST;
         low_ff     <= LOW_THR_RST;
         duty_on_ff <= DUTY_ON_RST;
         idle_ff    <= SIM_IDLE_RST;
         active_ff  <= SIM_ACTIVE_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.addr)
            REG_MANUAL_MODE: manual_ff  <= csr_chan.data[0];
            REG_SIMULATE:    sim_ff     <= csr_chan.data[0];
            REG_HIGH_THR:    high_ff    <= csr_chan.data[POWER_W-1:0];
            REG_LOW_THR:     low_ff     <= csr_chan.data[POWER_W-1:0];
            REG_DUTY_ON:     duty_on_ff <= csr_chan.data[DUTY_W-1:0];
            REG_SIM_IDLE:    idle_ff    <= csr_chan.data[POWER_W-1:0];
            REG_SIM_ACTIVE:  active_ff  <= csr_chan.data[POWER_W-1:0];
            default: ;
         endcase
      end
   end

   // a taken request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready)
      else $error("request taken but block still ready");

   // a measured sample restarts the time since the last good read
   assert property (@(posedge clock) disable iff (reset)
      req_take && !sim_ff && req_chan.energy_valid |=> since_ff == '0)
      else $error("good read did not clear the elapsed time");

   // an out-of-range quotient is reported as full scale
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) && sat |=> (power_ff == POWER_MAX) && (state_ff == S_DONE))
      else $error("saturated power not loaded");

   // in manual mode the throttle follows the duty window on each response
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready) && manual_ff
      |=> throttle_ff == $past(duty_on))
      else $error("manual throttle does not follow duty window");

endmodule
